// ===== rtl/block_request_splitter_core_defines.svh =====
// Assertion macros shared by the block request splitter RTL.
`ifndef BLOCK_REQUEST_SPLITTER_CORE_DEFINES_SVH
`define BLOCK_REQUEST_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BRS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/brs_pkg.sv =====
// Shared widths, codes and divider handshake types of the block request splitter.
`timescale 1ns / 1ps
package brs_pkg;

  localparam int FUNC_W      = 3;
  localparam int OFF_W       = 32;
  localparam int LEN_W       = 31;
  localparam int SIZE_W      = 13;
  localparam int TOTAL_W     = 19;
  localparam int POS_W       = 31;
  localparam int BOFF_W      = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 19;
  localparam int IN_TDATA_W  = 64;
  localparam int IN_PAD_W    = IN_TDATA_W - OFF_W - LEN_W;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + 4 * POS_W + BOFF_W + 1);
  localparam int DIV_W       = 32;
  localparam int DIV_STEPS_DEF = 2;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 13'd4096;

  localparam logic [FUNC_W-1:0] FN_SEEK_SET = 3'd0;
  localparam logic [FUNC_W-1:0] FN_SEEK_CUR = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SEEK_END = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ     = 3'd3;
  localparam logic [FUNC_W-1:0] FN_WRITE    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } brs_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [SIZE_W-1:0] rem;
  } brs_div_rsp_t;

endpackage

// ===== rtl/brs_div.sv =====
// Shared shift-subtract divider: 32-bit dividend by a 13-bit divisor.
`timescale 1ns / 1ps
`include "block_request_splitter_core_defines.svh"
module brs_div #(
  parameter int STEPS = brs_pkg::DIV_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  brs_pkg::brs_div_req_t req,
  output brs_pkg::brs_div_rsp_t rsp
);
  import brs_pkg::*;

  localparam int ITERS = DIV_W / STEPS;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  q_r, q_nxt;
  logic [SIZE_W-1:0] r_r, r_nxt;
  logic [SIZE_W-1:0] d_r, d_nxt;
  logic [DIV_W-1:0]  q_step;
  logic [SIZE_W-1:0] r_step;

  // Retire STEPS quotient bits per cycle.
  always_comb begin
    logic [SIZE_W:0] t;
    logic [SIZE_W:0] diff;
    r_step = r_r;
    q_step = q_r;
    for (int i = 0; i < STEPS; i++) begin
      t      = {r_step, q_step[DIV_W-1]};
      diff   = t - {1'b0, d_r};
      q_step = {q_step[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d_r}) begin
        r_step    = diff[SIZE_W-1:0];
        q_step[0] = 1'b1;
      end else begin
        r_step = t[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = req.dividend;
      r_nxt    = '0;
      d_nxt    = req.divisor;
    end else if (busy_r) begin
      q_nxt   = q_step;
      r_nxt   = r_step;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = r_r;

  `BRS_ASSERT_IMP(a_start_when_free, clk, rst_n, req.start, !busy_r, "divider restarted while busy")
  `BRS_ASSERT_IMP(a_done_when_free, clk, rst_n, done_r, !busy_r, "divider done while busy")
  `BRS_ASSERT_IMP(a_busy_from_start, clk, rst_n, $rose(busy_r), $past(req.start), "divider busy without start")

endmodule

// ===== rtl/block_request_splitter_core.sv =====
// Top level of the block request splitter: seek, clamp and split of sector I/O requests.
`timescale 1ns / 1ps
`include "block_request_splitter_core_defines.svh"
// The block keeps one byte position on a sector device and handles one item at a
// time. A seek (set, current, end) gives one result: status 1 and the position
// parked at the device capacity when the target is out of range or the offset is
// not a multiple of the effective block size. A read or write is clamped at the
// end of the device (the block-rounded end for writes) and split into at most
// three commands: an unaligned head, an aligned middle and a partial tail, each a
// result; the last one carries tlast. Writes count in erase blocks scaled to
// sectors. A zero length or an unknown function gives no result.
// All divisions go through one shift-subtract divider that retires DIV_STEPS bits
// a cycle, 2 by default. One 31x13 multiplier serves the capacity and the sector
// scaling. A wait on out_tready holds the item that is being worked on.
// in_tready stays low while an item is worked on. After reset and after every
// configuration write the block derives capacity, scale factor and write end
// before it takes the next item.
module block_request_splitter_core #(
  parameter int DIV_STEPS = brs_pkg::DIV_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // request items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [31:0] seek_offset, [62:32] length, [63] zero
  input  logic [brs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] func
  input  logic [brs_pkg::FUNC_W-1:0]      in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] status, [31:1] position, [62:32] first_sector, [93:63] count_sectors,
  // [105:94] byte_offset, [136:106] chunk_bytes, [137] needs_buffer, [143:138] zero
  output logic [brs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import brs_pkg::*;

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE      = 5'd0;
  localparam logic [ST_W-1:0] S_CFG_CAP   = 5'd1;
  localparam logic [ST_W-1:0] S_CFG_FGO   = 5'd2;
  localparam logic [ST_W-1:0] S_CFG_FWAIT = 5'd3;
  localparam logic [ST_W-1:0] S_CFG_TGO   = 5'd4;
  localparam logic [ST_W-1:0] S_CFG_TWAIT = 5'd5;
  localparam logic [ST_W-1:0] S_SEEK_GO   = 5'd6;
  localparam logic [ST_W-1:0] S_SEEK_WAIT = 5'd7;
  localparam logic [ST_W-1:0] S_CLAMP     = 5'd8;
  localparam logic [ST_W-1:0] S_POS_GO    = 5'd9;
  localparam logic [ST_W-1:0] S_POS_WAIT  = 5'd10;
  localparam logic [ST_W-1:0] S_HEAD      = 5'd11;
  localparam logic [ST_W-1:0] S_LEN_GO    = 5'd12;
  localparam logic [ST_W-1:0] S_LEN_WAIT  = 5'd13;
  localparam logic [ST_W-1:0] S_TAIL      = 5'd14;
  localparam logic [ST_W-1:0] S_MUL_IDX   = 5'd15;
  localparam logic [ST_W-1:0] S_MUL_CNT   = 5'd16;
  localparam logic [ST_W-1:0] S_EMIT      = 5'd17;

  localparam int PROD_W = POS_W + SIZE_W;
  localparam int SEEK_W = OFF_W + 2;

  // configuration registers
  logic [SIZE_W-1:0]  sector_size_r;
  logic [TOTAL_W-1:0] sector_total_r;
  logic [SIZE_W-1:0]  block_size_r;

  // derived geometry, refreshed after every configuration change
  logic              dirty_r, dirty_nxt;
  logic [POS_W-1:0]  cap_r, cap_nxt;
  logic [SIZE_W-1:0] fact_r, fact_nxt;
  logic [POS_W-1:0]  wtotal_r, wtotal_nxt;

  logic [ST_W-1:0]   state_r, state_nxt;
  logic [POS_W-1:0]  byte_position_r, byte_position_nxt;

  // item and split working registers
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [SIZE_W-1:0] unit_r, unit_nxt;
  logic [SIZE_W-1:0] fact_sel_r, fact_sel_nxt;
  logic [POS_W-1:0]  total_r, total_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [BOFF_W-1:0] m_r, m_nxt;

  // command being built
  logic              cmd_status_r, cmd_status_nxt;
  logic [POS_W-1:0]  cmd_pos_r, cmd_pos_nxt;
  logic [POS_W-1:0]  cmd_idx_r, cmd_idx_nxt;
  logic [POS_W-1:0]  cmd_first_r, cmd_first_nxt;
  logic [POS_W-1:0]  cmd_cnt_r, cmd_cnt_nxt;
  logic [BOFF_W-1:0] cmd_off_r, cmd_off_nxt;
  logic [LEN_W-1:0]  cmd_io_r, cmd_io_nxt;
  logic              cmd_nb_r, cmd_nb_nxt;
  logic              cmd_last_r, cmd_last_nxt;

  // output register
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                   out_tlast_r, out_tlast_nxt;
  logic                   out_free;
  logic                   out_load;

  // shared units
  brs_div_req_t      div_req;
  brs_div_rsp_t      div_rsp;
  logic [POS_W-1:0]  mul_a;
  logic [SIZE_W-1:0] mul_b;
  logic [PROD_W-1:0] prod_c;

  // effective sizes and seek arithmetic
  logic [SIZE_W-1:0] ss_c, bs_raw, bs_c;
  logic [OFF_W-1:0]  mag_c;
  logic [SEEK_W-1:0] off_ext, target_c;
  logic              seek_bad;
  logic [POS_W-1:0]  room_c;
  logic [SIZE_W-1:0] head_span;
  logic [LEN_W-1:0]  io_c;
  logic [POS_W-1:0]  ln_c;

  // Clamp the sizes; the block is never smaller than a sector.
  always_comb begin
    if (sector_size_r == '0) begin
      ss_c = SIZE_W'(1);
    end else if (sector_size_r > SIZE_MAX) begin
      ss_c = SIZE_MAX;
    end else begin
      ss_c = sector_size_r;
    end
    if (block_size_r == '0) begin
      bs_raw = SIZE_W'(1);
    end else if (block_size_r > SIZE_MAX) begin
      bs_raw = SIZE_MAX;
    end else begin
      bs_raw = block_size_r;
    end
    bs_c = (bs_raw < ss_c) ? ss_c : bs_raw;
  end

  // Seek target: two extra bits hold the sign and the carry of position plus offset.
  assign mag_c   = off_r[OFF_W-1] ? (~off_r + 1'b1) : off_r;
  assign off_ext = {{2{off_r[OFF_W-1]}}, off_r};
  always_comb begin
    case (func_r)
      FN_SEEK_END: target_c = {3'b000, cap_r};
      FN_SEEK_CUR: target_c = {3'b000, byte_position_r} + off_ext;
      default:     target_c = off_ext;
    endcase
    seek_bad = target_c[SEEK_W-1] || (target_c[SEEK_W-2:0] > {2'b00, cap_r}) ||
               (div_rsp.rem != '0);
  end

  assign room_c    = total_r - byte_position_r;
  assign head_span = unit_r - {1'b0, m_r};
  assign ln_c      = div_rsp.quot[POS_W-1:0];

  // Multiplier operands follow the sequencer.
  always_comb begin
    case (state_r)
      S_CFG_CAP: begin
        mul_a = {{(POS_W-TOTAL_W){1'b0}}, sector_total_r};
        mul_b = ss_c;
      end
      S_MUL_CNT: begin
        mul_a = cmd_cnt_r;
        mul_b = fact_sel_r;
      end
      default: begin
        mul_a = cmd_idx_r;
        mul_b = fact_sel_r;
      end
    endcase
  end
  assign prod_c = mul_a * mul_b;

  // Divider requests by state.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, len_r};
    div_req.divisor  = unit_r;
    case (state_r)
      S_CFG_FGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(DIV_W-SIZE_W){1'b0}}, bs_c};
        div_req.divisor  = ss_c;
      end
      S_CFG_TGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, cap_r};
        div_req.divisor  = bs_c;
      end
      S_SEEK_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mag_c;
        div_req.divisor  = bs_c;
      end
      S_POS_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, pos_r};
      end
      S_LEN_GO: begin
        div_req.start = 1'b1;
      end
      default: ;
    endcase
  end

  brs_div #(
    .STEPS(DIV_STEPS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready = (state_r == S_IDLE) && !dirty_r;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_EMIT) && out_free;

  // Sequencer.
  always_comb begin
    state_nxt         = state_r;
    dirty_nxt         = dirty_r || cfg_we;
    cap_nxt           = cap_r;
    fact_nxt          = fact_r;
    wtotal_nxt        = wtotal_r;
    byte_position_nxt = byte_position_r;
    func_nxt          = func_r;
    off_nxt           = off_r;
    len_nxt           = len_r;
    unit_nxt          = unit_r;
    fact_sel_nxt      = fact_sel_r;
    total_nxt         = total_r;
    pos_nxt           = pos_r;
    idx_nxt           = idx_r;
    m_nxt             = m_r;
    cmd_status_nxt    = cmd_status_r;
    cmd_pos_nxt       = cmd_pos_r;
    cmd_idx_nxt       = cmd_idx_r;
    cmd_first_nxt     = cmd_first_r;
    cmd_cnt_nxt       = cmd_cnt_r;
    cmd_off_nxt       = cmd_off_r;
    cmd_io_nxt        = cmd_io_r;
    cmd_nb_nxt        = cmd_nb_r;
    cmd_last_nxt      = cmd_last_r;
    io_c              = '0;

    unique case (state_r)
      S_IDLE: begin
        if (dirty_r) begin
          dirty_nxt = cfg_we;
          state_nxt = S_CFG_CAP;
        end else if (in_tvalid) begin
          func_nxt = in_tuser;
          off_nxt  = in_tdata[OFF_W-1:0];
          len_nxt  = in_tdata[OFF_W+LEN_W-1:OFF_W];
          unique case (in_tuser) inside
            FN_SEEK_SET, FN_SEEK_CUR, FN_SEEK_END: begin
              state_nxt = S_SEEK_GO;
            end
            FN_READ: begin
              unit_nxt     = ss_c;
              fact_sel_nxt = SIZE_W'(1);
              total_nxt    = cap_r;
              state_nxt    = S_CLAMP;
            end
            FN_WRITE: begin
              unit_nxt     = bs_c;
              fact_sel_nxt = fact_r;
              total_nxt    = wtotal_r;
              state_nxt    = S_CLAMP;
            end
            default: ;  // drop unknown functions
          endcase
        end
      end
      S_CFG_CAP: begin
        cap_nxt   = prod_c[POS_W-1:0];
        state_nxt = S_CFG_FGO;
      end
      S_CFG_FGO: state_nxt = S_CFG_FWAIT;
      S_CFG_FWAIT: begin
        if (div_rsp.done) begin
          fact_nxt  = div_rsp.quot[SIZE_W-1:0];
          state_nxt = S_CFG_TGO;
        end
      end
      S_CFG_TGO: state_nxt = S_CFG_TWAIT;
      S_CFG_TWAIT: begin
        // write end: capacity rounded down to whole blocks
        if (div_rsp.done) begin
          wtotal_nxt = cap_r - {{(POS_W-SIZE_W){1'b0}}, div_rsp.rem};
          state_nxt  = S_IDLE;
        end
      end
      S_SEEK_GO: state_nxt = S_SEEK_WAIT;
      S_SEEK_WAIT: begin
        if (div_rsp.done) begin
          cmd_status_nxt = seek_bad;
          cmd_pos_nxt    = seek_bad ? cap_r : target_c[POS_W-1:0];
          cmd_first_nxt  = '0;
          cmd_cnt_nxt    = '0;
          cmd_off_nxt    = '0;
          cmd_io_nxt     = '0;
          cmd_nb_nxt     = 1'b0;
          cmd_last_nxt   = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_CLAMP: begin
        // drop requests of zero length or that start at or past the end
        if (byte_position_r >= total_r || len_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          len_nxt   = (len_r > room_c) ? room_c : len_r;
          pos_nxt   = byte_position_r;
          state_nxt = S_POS_GO;
        end
      end
      S_POS_GO: state_nxt = S_POS_WAIT;
      S_POS_WAIT: begin
        if (div_rsp.done) begin
          idx_nxt   = div_rsp.quot[POS_W-1:0];
          m_nxt     = div_rsp.rem[BOFF_W-1:0];
          state_nxt = (div_rsp.rem != '0) ? S_HEAD : S_LEN_GO;
        end
      end
      S_HEAD: begin
        io_c = (len_r < {{(LEN_W-SIZE_W){1'b0}}, head_span}) ?
               len_r : {{(LEN_W-SIZE_W){1'b0}}, head_span};
        cmd_status_nxt = 1'b0;
        cmd_idx_nxt    = idx_r;
        cmd_cnt_nxt    = POS_W'(1);
        cmd_off_nxt    = m_r;
        cmd_io_nxt     = io_c;
        cmd_nb_nxt     = 1'b1;
        cmd_last_nxt   = (len_r == io_c);
        cmd_pos_nxt    = pos_r + io_c;
        pos_nxt        = pos_r + io_c;
        len_nxt        = len_r - io_c;
        idx_nxt        = idx_r + 1'b1;
        state_nxt      = S_MUL_IDX;
      end
      S_LEN_GO: state_nxt = S_LEN_WAIT;
      S_LEN_WAIT: begin
        if (div_rsp.done) begin
          cmd_status_nxt = 1'b0;
          cmd_idx_nxt    = idx_r;
          cmd_off_nxt    = '0;
          if (ln_c != '0) begin
            // aligned middle: whole units only
            io_c        = len_r - {{(LEN_W-SIZE_W){1'b0}}, div_rsp.rem};
            cmd_cnt_nxt = ln_c;
            cmd_nb_nxt  = 1'b0;
          end else begin
            // shorter than one unit: partial tail
            io_c        = len_r;
            cmd_cnt_nxt = POS_W'(1);
            cmd_nb_nxt  = 1'b1;
          end
          cmd_io_nxt   = io_c;
          cmd_last_nxt = (len_r == io_c);
          cmd_pos_nxt  = pos_r + io_c;
          pos_nxt      = pos_r + io_c;
          len_nxt      = len_r - io_c;
          idx_nxt      = idx_r + ln_c;
          state_nxt    = S_MUL_IDX;
        end
      end
      S_TAIL: begin
        // remainder after a middle is below one unit
        cmd_status_nxt = 1'b0;
        cmd_idx_nxt    = idx_r;
        cmd_cnt_nxt    = POS_W'(1);
        cmd_off_nxt    = '0;
        cmd_io_nxt     = len_r;
        cmd_nb_nxt     = 1'b1;
        cmd_last_nxt   = 1'b1;
        cmd_pos_nxt    = pos_r + len_r;
        pos_nxt        = pos_r + len_r;
        len_nxt        = '0;
        state_nxt      = S_MUL_IDX;
      end
      S_MUL_IDX: begin
        cmd_first_nxt = prod_c[POS_W-1:0];
        state_nxt     = S_MUL_CNT;
      end
      S_MUL_CNT: begin
        cmd_cnt_nxt = prod_c[POS_W-1:0];
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        // hold the command until the output register frees up
        if (out_free) begin
          if (cmd_last_r) begin
            byte_position_nxt = cmd_pos_r;
            state_nxt         = S_IDLE;
          end else if (cmd_nb_r) begin
            state_nxt = S_LEN_GO;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load a finished command, drop it once taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, cmd_nb_r, cmd_io_r, cmd_off_r, cmd_cnt_r,
                        cmd_first_r, cmd_pos_r, cmd_status_r};
      out_tlast_nxt  = cmd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      dirty_r         <= 1'b1;
      byte_position_r <= '0;
      out_tvalid_r    <= 1'b0;
      sector_size_r   <= SIZE_W'(512);
      sector_total_r  <= '0;
      block_size_r    <= SIZE_W'(512);
    end else begin
      state_r         <= state_nxt;
      dirty_r         <= dirty_nxt;
      byte_position_r <= byte_position_nxt;
      out_tvalid_r    <= out_tvalid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SECTOR_SIZE:  sector_size_r  <= cfg_wdata[SIZE_W-1:0];
          CFG_SECTOR_TOTAL: sector_total_r <= cfg_wdata[TOTAL_W-1:0];
          CFG_BLOCK_SIZE:   block_size_r   <= cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_r        <= cap_nxt;
    fact_r       <= fact_nxt;
    wtotal_r     <= wtotal_nxt;
    func_r       <= func_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    unit_r       <= unit_nxt;
    fact_sel_r   <= fact_sel_nxt;
    total_r      <= total_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    m_r          <= m_nxt;
    cmd_status_r <= cmd_status_nxt;
    cmd_pos_r    <= cmd_pos_nxt;
    cmd_idx_r    <= cmd_idx_nxt;
    cmd_first_r  <= cmd_first_nxt;
    cmd_cnt_r    <= cmd_cnt_nxt;
    cmd_off_r    <= cmd_off_nxt;
    cmd_io_r     <= cmd_io_nxt;
    cmd_nb_r     <= cmd_nb_nxt;
    cmd_last_r   <= cmd_last_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tlast_r  <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `BRS_ASSERT_NXT(a_cfg_blocks_intake, clk, rst_n, cfg_we, !in_tready, "item taken on stale geometry")
  `BRS_ASSERT_IMP(a_split_moves_bytes, clk, rst_n, out_load && (func_r == FN_READ || func_r == FN_WRITE), cmd_io_r != '0, "empty split command")
  `BRS_ASSERT_NXT(a_last_ends_item, clk, rst_n, out_load && cmd_last_r, state_r == S_IDLE, "work after final command")

endmodule

// ===== tb/block_request_splitter_core_test.sv =====
// Self-checking testbench of the block request splitter: seeks, clamps and sector command splits.
`timescale 1ns / 1ps
module block_request_splitter_core_test;
  import brs_pkg::*;

  // Timing: 10 ns clock, reset held at the start, idle margin after each phase
  // long enough for an item that gives no result to retire.
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_PRINTS    = 60;

  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  // Function codes above write are ignored by the block.
  localparam logic [FUNC_W-1:0] FN_CODE_TOP     = '1;
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = FN_WRITE + 3'd1;

  // Register settings, one per phase. Phase 0 also carries the directed items.
  localparam int PH_N         = 10;
  localparam int PARK_PHASE   = 8;  // ends with the position parked at capacity
  localparam int SHRINK_PHASE = 9;  // then the capacity shrinks under it
  int unsigned ph_sector[PH_N] = '{512, 1,    4096,   3,   1024, 0,    8191, 512,  512,  512};
  int unsigned ph_total[PH_N]  = '{1001, 0,   524287, 700, 300,  5000, 2,    64,   1001, 100};
  int unsigned ph_block[PH_N]  = '{4096, 1,   4096,   8,   512,  8191, 0,    2048, 4096, 512};
  int unsigned ph_rand[PH_N]   = '{40,   20,  50,     50,  40,   40,   30,   40,   5,    35};
  bit          ph_calm[PH_N]   = '{0,    0,   0,      0,   0,    0,    0,    1,    0,    0};
  bit          ph_drain[PH_N]  = '{0,    0,   0,      1,   0,    0,    0,    1,    0,    0};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [OFF_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic              drain;   // hold this item until every command has come back
  } request_t;

  typedef struct packed {
    logic              status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  first_sector;
    logic [POS_W-1:0]  count_sectors;
    logic [BOFF_W-1:0] byte_offset;
    logic [POS_W-1:0]  chunk_bytes;
    logic              needs_buffer;
    logic              last;
  } cmd_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]      in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  // Shadow of the block: register copies and the byte position.
  logic [SIZE_W-1:0]  sector_size_q  = 13'd512;
  logic [TOTAL_W-1:0] sector_total_q = '0;
  logic [SIZE_W-1:0]  block_size_q   = 13'd512;
  logic [POS_W-1:0]   byte_pos       = '0;

  request_t    request_backlog[$];
  cmd_result_t expected_cmds[$];
  request_t    in_flight;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned requests_taken = 0;
  int unsigned seeks_rejected = 0;
  int unsigned three_way      = 0;
  int unsigned commands_seen  = 0;
  int unsigned settings_used  = 0;

  block_request_splitter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective geometry: clamp both sizes to 1..4096, then never let the
  // erase block be smaller than the sector.
  function automatic longint eff_sector_bytes();
    longint s;
    s = sector_size_q;
    if (s < 1) s = 1;
    if (s > SIZE_MAX) s = SIZE_MAX;
    return s;
  endfunction

  function automatic longint eff_block_bytes();
    longint b;
    b = block_size_q;
    if (b < 1) b = 1;
    if (b > SIZE_MAX) b = SIZE_MAX;
    if (b < eff_sector_bytes()) b = eff_sector_bytes();
    return b;
  endfunction

  function automatic longint capacity_bytes();
    return eff_sector_bytes() * longint'(sector_total_q);
  endfunction

  // Clamp a transfer at the end of the span, then cut it into head, middle and
  // tail commands. Index and count are scaled by fact for erase-block writes.
  function automatic void split_transfer(longint unit, longint nunits, longint fact,
                                         longint len);
    longint span, pos, rem, idx, cnt, io, off, whole;
    logic nb;
    int n;
    cmd_result_t c;
    span = unit * nunits;
    pos  = byte_pos;
    n    = 0;
    if (pos >= span) len = 0;
    else if (len > span - pos) len = span - pos;
    while (len > 0 && n < 3) begin
      rem = pos % unit;
      idx = pos / unit;
      off = 0;
      if (rem != 0) begin
        // unaligned head: finish the current unit through a bounce buffer
        cnt = 1;
        off = rem;
        io  = unit - rem;
        nb  = 1'b1;
        if (io > len) io = len;
      end else begin
        whole = len / unit;
        if (whole != 0) begin
          cnt = whole;
          io  = whole * unit;
          nb  = 1'b0;
        end else begin
          cnt = 1;
          io  = len;
          nb  = 1'b1;
        end
      end
      pos += io;
      len -= io;
      c.status        = ST_OK;
      c.position      = POS_W'(pos);
      c.first_sector  = POS_W'(idx * fact);
      c.count_sectors = POS_W'(cnt * fact);
      c.byte_offset   = BOFF_W'(off);
      c.chunk_bytes   = POS_W'(io);
      c.needs_buffer  = nb;
      c.last          = (len == 0);
      expected_cmds.push_back(c);
      n++;
    end
    if (n == 3) three_way++;
    byte_pos = POS_W'(pos);
  endfunction

  // Work out the commands of one accepted item and advance the shadow position.
  function automatic void predict_commands(request_t r);
    longint ss, bs, cap, off_s, mag, target;
    bit bad;
    cmd_result_t c;
    ss  = eff_sector_bytes();
    bs  = eff_block_bytes();
    cap = capacity_bytes();
    requests_taken++;
    if (r.func <= FN_SEEK_END) begin
      off_s = longint'($signed(r.offset));
      mag   = (off_s < 0) ? -off_s : off_s;
      if (r.func == FN_SEEK_END) target = cap;
      else if (r.func == FN_SEEK_CUR) target = longint'(byte_pos) + off_s;
      else target = off_s;
      // out of range or misaligned: park at capacity and flag it
      bad = (target < 0) || (target > cap) || (mag % bs != 0);
      byte_pos = bad ? POS_W'(cap) : POS_W'(target);
      if (bad) seeks_rejected++;
      c          = '0;
      c.status   = bad ? ST_REJECT : ST_OK;
      c.position = byte_pos;
      c.last     = 1'b1;
      expected_cmds.push_back(c);
    end else if (r.func == FN_READ) begin
      split_transfer(ss, longint'(sector_total_q), 1, longint'(r.length));
    end else if (r.func == FN_WRITE) begin
      split_transfer(bs, cap / bs, bs / ss, longint'(r.length));
    end else begin
      requests_taken--;   // unknown code: ignored, nothing changes
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Mostly short idles, a few long ones.
  function automatic int unsigned pick_idle();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(20, 4);
    return $urandom_range(150, 40);
  endfunction

  function automatic logic [LEN_W-1:0] random_length(longint unit);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return '0;
    if (roll < 40) return LEN_W'($urandom_range(unit, 1));
    if (roll < 88) return LEN_W'(unit * $urandom_range(8, 0) + $urandom_range(unit - 1, 0));
    return LEN_W'($urandom);
  endfunction

  // Mostly well-formed traffic for the current geometry, some noise.
  function automatic request_t random_request();
    request_t r;
    longint ss, bs, cap;
    int unsigned roll;
    ss   = eff_sector_bytes();
    bs   = eff_block_bytes();
    cap  = capacity_bytes();
    r    = '0;
    roll = $urandom_range(99, 0);
    if (roll < 22) begin
      r.func   = FN_SEEK_SET;
      r.offset = OFF_W'(bs * $urandom_range(cap / bs, 0));
    end else if (roll < 32) begin
      r.func   = FN_SEEK_CUR;
      r.offset = OFF_W'(bs * $urandom_range(4, 0));
      if ($urandom_range(1, 0) != 0) r.offset = -r.offset;
    end else if (roll < 36) begin
      r.func   = FN_SEEK_END;
      r.offset = OFF_W'(bs * $urandom_range(2, 0));
      if ($urandom_range(1, 0) != 0) r.offset = -r.offset;
    end else if (roll < 60) begin
      r.func   = FN_READ;
      r.length = random_length(ss);
    end else if (roll < 84) begin
      r.func   = FN_WRITE;
      r.length = random_length(bs);
    end else begin
      r.func   = FUNC_W'($urandom_range(FN_CODE_TOP, 0));
      r.offset = $urandom;
      r.length = ($urandom_range(1, 0) != 0) ? LEN_W'($urandom) : random_length(ss);
    end
    return r;
  endfunction

  task automatic add_request(logic [FUNC_W-1:0] func, logic [OFF_W-1:0] offset,
                             logic [LEN_W-1:0] length);
    request_t r;
    r.func   = func;
    r.offset = offset;
    r.length = length;
    r.drain  = 1'b0;
    request_backlog.push_back(r);
  endtask

  // Register writes come only when no item is in flight; the shadow follows.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SECTOR_SIZE:  sector_size_q  = value[SIZE_W-1:0];
      CFG_SECTOR_TOTAL: sector_total_q = value[TOTAL_W-1:0];
      CFG_BLOCK_SIZE:   block_size_q   = value[SIZE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until nothing is queued, offered or expected, then let a silent item retire.
  task automatic wait_until_drained();
    while (request_backlog.size() != 0 || in_tvalid || expected_cmds.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Request driver: predict on acceptance, then offer the next item after its gap.
  always @(posedge clk) begin : request_driver
    request_t nxt;
    bit fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) predict_commands(in_flight);
      if (!in_tvalid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (request_backlog.size() != 0 &&
                     !(request_backlog[0].drain && expected_cmds.size() != 0)) begin
          nxt       = request_backlog.pop_front();
          in_flight = nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= {{IN_PAD_W{1'b0}}, nxt.length, nxt.offset};
          in_tuser  <= nxt.func;
          gap_left  = calm ? 0 : pick_idle();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each command against the oldest expectation and
  // throttle out_tready with random stalls.
  always @(posedge clk) begin : result_monitor
    cmd_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status        = out_tdata[0];
        got.position      = out_tdata[31:1];
        got.first_sector  = out_tdata[62:32];
        got.count_sectors = out_tdata[93:63];
        got.byte_offset   = out_tdata[105:94];
        got.chunk_bytes   = out_tdata[136:106];
        got.needs_buffer  = out_tdata[137];
        got.last          = out_tlast;
        commands_seen++;
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected command (position)", got.position, 0);
        end else begin
          want = expected_cmds.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.position !== want.position)
            report_mismatch("position", got.position, want.position);
          if (got.first_sector !== want.first_sector)
            report_mismatch("first_sector", got.first_sector, want.first_sector);
          if (got.count_sectors !== want.count_sectors)
            report_mismatch("count_sectors", got.count_sectors, want.count_sectors);
          if (got.byte_offset !== want.byte_offset)
            report_mismatch("byte_offset", got.byte_offset, want.byte_offset);
          if (got.chunk_bytes !== want.chunk_bytes)
            report_mismatch("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
          if (got.needs_buffer !== want.needs_buffer)
            report_mismatch("needs_buffer", got.needs_buffer, want.needs_buffer);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        end
      end
      if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(3, 0) == 0) stall_left = pick_idle();
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : sequencer
    int unsigned made;
    request_t r;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < PH_N; ph++) begin
      calm = ph_calm[ph];
      write_reg(CFG_SECTOR_SIZE,  CFG_DATA_W'(ph_sector[ph]));
      write_reg(CFG_SECTOR_TOTAL, CFG_DATA_W'(ph_total[ph]));
      write_reg(CFG_BLOCK_SIZE,   CFG_DATA_W'(ph_block[ph]));
      settings_used++;

      if (ph == 0) begin
        // Geometry here: 512 byte sectors, capacity 512512, 4 KiB erase blocks,
        // so the write end (512000) lies below the capacity.
        add_request(FN_SEEK_SET, 0, 0);
        add_request(FN_READ, 0, 1000);            // middle plus tail
        add_request(FN_READ, 0, 2000);            // head, middle and tail
        add_request(FN_WRITE, 0, 10000);          // scaled head, middle and tail
        add_request(FN_READ, 0, 0);               // zero length: nothing
        add_request(FN_SEEK_SET, 100, 0);         // misaligned: park at capacity
        add_request(FN_READ, 0, 10);              // at the end: nothing
        add_request(FN_WRITE, 0, 10);             // past the write end: nothing
        add_request(FN_SEEK_CUR, -8192, 0);
        add_request(FN_READ, 0, '1);              // clamp the longest read
        add_request(FN_SEEK_SET, -4096, 0);       // negative target
        add_request(FN_SEEK_SET, 32'h8000_0000, 0);
        add_request(FN_SEEK_SET, 32'h7FFF_F000, 0);  // aligned but beyond capacity
        add_request(FN_SEEK_SET, 32'h7FFF_FFFF, 0);
        add_request(FN_SEEK_END, 0, 0);
        add_request(FN_SEEK_END, 100, 0);         // end target, misaligned offset
        add_request(FN_SEEK_SET, 4096, 0);
        add_request(FN_READ, 0, 100);             // short tail only
        add_request(FN_WRITE, 0, '1);             // clamp the longest write at the write end
        add_request(FN_SEEK_CUR, 0, 0);
        add_request(FN_SEEK_CUR, 4096, 0);        // runs past capacity
        add_request(FN_FIRST_UNUSED, $urandom, LEN_W'($urandom));
        add_request(FN_FIRST_UNUSED + 3'd1, $urandom, LEN_W'($urandom));
        add_request(FN_CODE_TOP, '1, '1);
      end
      if (ph == SHRINK_PHASE) begin
        // position left beyond the new capacity: no command from either side
        add_request(FN_READ, 0, 100);
        add_request(FN_WRITE, 0, 100);
      end

      made = 0;
      while (made < ph_rand[ph]) begin
        r       = random_request();
        r.drain = ph_drain[ph] && (made == ph_rand[ph] / 2);
        request_backlog.push_back(r);
        if (r.func <= FN_WRITE) made++;
      end
      if (ph == PARK_PHASE) add_request(FN_SEEK_END, 0, 0);

      wait_until_drained();
    end

    $display("Covered %0d requests over %0d register settings: %0d rejected seeks,",
             requests_taken, settings_used, seeks_rejected);
    $display("%0d sector commands checked, %0d transfers split three ways.",
             commands_seen, three_way);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
